// ===== sv/bnd_pkg.sv =====
// ----------------------------------------------------------------------------
// bnd_pkg
// Shared types and constants for the breakpoint lookup core.
// ----------------------------------------------------------------------------
package bnd_pkg;

	localparam int MAX_POINTS_DEF = 16;
	localparam int PADDR_W        = 3;

	localparam logic [4:0]  POINTS_RESET = 5'd16;
	localparam logic [15:0] DIST_SAT     = 16'hFFFF;
	localparam logic        REG_POINTS   = 1'b0;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [3:0]  entry_index;
		logic [15:0] entry_value;
		logic [15:0] query_value;
	} req_t;

	typedef struct packed {
		logic [3:0]  point_index;
		logic [15:0] distance_q14;
		logic        clipped;
	} rsp_t;

	typedef struct packed {
		logic [17:0] diff;
		logic        neg;
		logic        zero;
	} sub_res_t;

endpackage

// ===== sv/bnd_sub_unit.sv =====
// ----------------------------------------------------------------------------
// bnd_sub_unit
// Shared 17-bit subtractor with sign and zero flags, used for every compare,
// difference and divide step of the sequencer.
// ----------------------------------------------------------------------------
module bnd_sub_unit (
	input  logic [16:0]       a,
	input  logic [16:0]       b,
	output bnd_pkg::sub_res_t res
);

	logic [17:0] diff;

	assign diff     = {1'b0, a} - {1'b0, b};
	assign res.diff = diff;
	assign res.neg  = diff[17];
	assign res.zero = (diff == 18'd0);

endmodule

// ===== sv/breakpoint_nearest_with_distance_core.sv =====
// ----------------------------------------------------------------------------
// breakpoint_nearest_with_distance_core
// Nearest-breakpoint lookup with relative distance 2*|q-p|/span in Q2.14.
// The breakpoint scan and the 16-step divide share one subtractor. A table
//   write gives no word. Lookups do not overlap: a new request is taken only
//   once the last lookup's word is loaded, and req_stall is high while busy.
// Reset: arst_n clears the sequencer, output valid and points_in_use (to 16);
//   the breakpoint table is not cleared.
// ----------------------------------------------------------------------------
module breakpoint_nearest_with_distance_core #(
	parameter int MAX_POINTS = bnd_pkg::MAX_POINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        req_valid,
	output logic                        req_stall,
	input  bnd_pkg::req_t               req,

	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output bnd_pkg::rsp_t               rsp,

	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bnd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_RA    = 4'd3;
	localparam logic [3:0] S_CMP   = 4'd4;
	localparam logic [3:0] S_NEG   = 4'd5;
	localparam logic [3:0] S_ABOVE = 4'd6;
	localparam logic [3:0] S_SPAN  = 4'd7;
	localparam logic [3:0] S_SAT   = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]        state_q;
	logic [4:0]        points_q;
	logic [15:0]       mem [MAX_POINTS];
	logic [15:0]       rdata_q;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     last_q;
	logic [AW-1:0]     last_d;
	logic [AW-1:0]     idx_q;
	logic [15:0]       q_q;
	logic [15:0]       lo_q;
	logic [15:0]       hi_q;
	logic [15:0]       ra_q;
	logic [15:0]       diff_q;
	logic [15:0]       span_q;
	logic [15:0]       rem_q;
	logic              nb_q;
	logic [15:0]       quot_q;
	logic [3:0]        cnt_q;
	logic              sat_q;
	logic              rsp_valid_q;
	bnd_pkg::rsp_t     rsp_q;
	logic [16:0]       op_a;
	logic [16:0]       op_b;
	bnd_pkg::sub_res_t sub;
	logic              req_acc;
	logic              wr_ok;
	logic              cfg_wr;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == bnd_pkg::REG_POINTS) ? {27'd0, points_q} : 32'd0;
	assign wr_ok     = (32'(req.entry_index) < 32'(MAX_POINTS));

	// clamp points_in_use to [2, MAX_POINTS], minus one
	always_comb begin
		if (points_q < 5'd2) begin
			last_d = AW'(1);
		end else if (32'(points_q) > 32'(MAX_POINTS)) begin
			last_d = AW'(MAX_POINTS - 1);
		end else begin
			last_d = AW'(points_q - 5'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= bnd_pkg::POINTS_RESET;
		end else if (cfg_wr && paddr[2] == bnd_pkg::REG_POINTS) begin
			points_q <= pwdata[4:0];
		end
	end

	// breakpoint table
	always_comb begin
		unique case (state_q)
			S_LOAD:  rd_addr = AW'(1);
			S_SCAN:  rd_addr = i_q + 1'b1;
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_acc && req.mode == bnd_pkg::MODE_WRITE && wr_ok) begin
			mem[AW'(req.entry_index)] <= req.entry_value;
		end
		rdata_q <= mem[rd_addr];
	end

	// shared subtractor operands
	always_comb begin
		unique case (state_q)
			S_SCAN: begin
				op_a = {1'b0, rdata_q};
				op_b = {1'b0, q_q};
			end
			S_RA: begin
				op_a = {1'b0, q_q};
				op_b = {1'b0, lo_q};
			end
			S_CMP: begin
				op_a = {1'b0, ra_q};
				op_b = {1'b0, diff_q};
			end
			S_NEG: begin
				op_a = {1'b0, lo_q};
				op_b = {1'b0, q_q};
			end
			S_ABOVE: begin
				op_a = {1'b0, q_q};
				op_b = {1'b0, hi_q};
			end
			S_SPAN: begin
				op_a = {1'b0, hi_q};
				op_b = {1'b0, lo_q};
			end
			S_SAT: begin
				op_a = {1'b0, diff_q};
				op_b = {span_q, 1'b0};
			end
			S_DIV: begin
				op_a = {rem_q, nb_q};
				op_b = {1'b0, span_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	bnd_sub_unit u_sub (
		.a   (op_a),
		.b   (op_b),
		.res (sub)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && req.mode == bnd_pkg::MODE_LOOKUP) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: state_q <= S_SCAN;
				S_SCAN: begin
					if (!sub.neg) begin
						state_q <= S_RA;
					end else if (i_q == last_q) begin
						state_q <= S_ABOVE;
					end
				end
				S_RA:    state_q <= sub.neg ? S_NEG : S_CMP;
				S_CMP:   state_q <= S_SPAN;
				S_NEG:   state_q <= S_SPAN;
				S_ABOVE: state_q <= S_SPAN;
				S_SPAN:  state_q <= (sub.neg || sub.zero) ? S_DONE : S_SAT;
				S_SAT:   state_q <= sub.neg ? S_DIV : S_DONE;
				S_DIV: begin
					if (cnt_q == 4'd0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				q_q    <= req.query_value;
				last_q <= last_d;
			end
			S_LOAD: begin
				lo_q <= rdata_q;
				i_q  <= AW'(1);
			end
			S_SCAN: begin
				if (!sub.neg) begin
					hi_q   <= rdata_q;
					diff_q <= sub.diff[15:0];
				end else if (i_q == last_q) begin
					hi_q  <= rdata_q;
					idx_q <= i_q;
				end else begin
					lo_q <= rdata_q;
					i_q  <= i_q + 1'b1;
				end
			end
			S_RA: begin
				ra_q <= sub.diff[15:0];
				if (sub.neg) begin
					idx_q <= i_q - 1'b1;
				end
			end
			S_CMP: begin
				if (sub.neg) begin
					idx_q  <= i_q - 1'b1;
					diff_q <= ra_q;
				end else begin
					idx_q <= i_q;
				end
			end
			S_NEG:   diff_q <= sub.diff[15:0];
			S_ABOVE: diff_q <= sub.diff[15:0];
			S_SPAN: begin
				span_q <= sub.diff[15:0];
				sat_q  <= sub.neg || sub.zero;
			end
			S_SAT: begin
				sat_q <= !sub.neg;
				rem_q <= {1'b0, diff_q[15:1]};
				nb_q  <= diff_q[0];
				cnt_q <= 4'd15;
			end
			S_DIV: begin
				rem_q  <= sub.neg ? op_a[15:0] : sub.diff[15:0];
				quot_q <= {quot_q[14:0], !sub.neg};
				nb_q   <= 1'b0;
				cnt_q  <= cnt_q - 4'd1;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q.point_index  <= 4'(idx_q);
					rsp_q.distance_q14 <= sat_q ? bnd_pkg::DIST_SAT : quot_q;
					rsp_q.clipped      <= sat_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/bnd_checker.sv =====
// ----------------------------------------------------------------------------
// bnd_checker
// Port-level checks for the breakpoint lookup core, bound to breakpoint_nearest_with_distance_core.
// ----------------------------------------------------------------------------
module bnd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input bnd_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input bnd_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response word changed");

	a_busy_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.mode == bnd_pkg::MODE_LOOKUP |=> req_stall)
		else $error("lookup accepted without going busy");

	a_write_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.mode == bnd_pkg::MODE_WRITE && !rsp_valid
		|=> !rsp_valid)
		else $error("table write produced a word");

	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.clipped |-> rsp.distance_q14 == bnd_pkg::DIST_SAT)
		else $error("clipped word without saturated distance");

endmodule

bind breakpoint_nearest_with_distance_core bnd_checker u_bnd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
